[src/dsmg_pkg.sv]
// Package for the dispersion sweep core: shared constants, types and the
// saturation helper. No dependencies.
`timescale 1ns / 1ps
package dsmg_pkg;

    // Width of the wide intermediate used for sums and saturation
    localparam int XW = 80;

    // 2*pi with 32 fraction bits
    localparam logic [63:0] TWO_PI_Q32 = 64'd26986075410;

    localparam logic signed [31:0] INT32_MIN_C = 32'sh8000_0000;
    localparam logic signed [31:0] INT32_MAX_C = 32'sh7FFF_FFFF;

    // Configuration register indexes
    localparam logic [2:0] REG_SELF1  = 3'd0;
    localparam logic [2:0] REG_CROSS1 = 3'd1;
    localparam logic [2:0] REG_CROSS2 = 3'd2;
    localparam logic [2:0] REG_SELF2  = 3'd3;
    localparam logic [2:0] REG_DIFF1  = 3'd4;
    localparam logic [2:0] REG_DIFF2  = 3'd5;
    localparam logic [2:0] REG_KSTART = 3'd6;
    localparam logic [2:0] REG_KSTEP  = 3'd7;

    // Request to the shared multiplier
    typedef struct packed {
        logic               en;
        logic signed [32:0] a;
        logic signed [32:0] b;
    } mul_req_t;

    // Clamp a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
        logic signed [31:0] r;
        if (v > XW'(INT32_MAX_C))
            r = INT32_MAX_C;
        else if (v < XW'(INT32_MIN_C))
            r = INT32_MIN_C;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[src/dsmg_if.sv]
// Item channel interfaces for the dispersion sweep core.
// Depends on nothing.
`timescale 1ns / 1ps
interface dsmg_in_if;
    logic valid;
    logic ready;
    logic final_point;

    modport source (output valid, output final_point, input ready);
    modport sink   (input valid, input final_point, output ready);
endinterface

interface dsmg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] wavenumber;
    logic signed [31:0] growth_rate;
    logic               sweep_done;
    logic signed [31:0] critical_wavenumber;
    logic signed [31:0] critical_rate;
    logic               unstable;
    logic [30:0]        wavelength;

    modport source (output valid, output wavenumber, output growth_rate,
                    output sweep_done, output critical_wavenumber,
                    output critical_rate, output unstable, output wavelength,
                    input ready);
    modport sink   (input valid, input wavenumber, input growth_rate,
                    input sweep_done, input critical_wavenumber,
                    input critical_rate, input unstable, input wavelength,
                    output ready);
endinterface

[src/dsmg_mul.sv]
// Shared 33x33 signed multiplier with registered product.
// Depends on dsmg_pkg.
`timescale 1ns / 1ps
module dsmg_mul
    import dsmg_pkg::*;
(
    input  logic               clk,
    input  mul_req_t           req,
    output logic signed [65:0] prod_reg
);

    logic signed [65:0] prod_next;

    assign prod_next = req.a * req.b;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

[src/dispersion_sweep_max_growth_core.sv]
// Top level of the dispersion sweep core: register file, sequencer, square
// root and divide iterations. Depends on dsmg_pkg, dsmg_if and dsmg_mul.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Usage
//   sweep_in   : one item per sweep point; final_point marks the last point.
//   result_out : one item per point with k, the growth rate, the running
//                maximum and its k; on the last point also the unstable flag
//                and the wavelength 2*pi over the critical k.
//   APB port   : eight 32-bit registers at byte addresses 0..28; the user must
//                write them only while the block is idle; the block does not enforce it.
// Flow
//   An item runs through the multiply and combine steps of the sequencer,
//   then the restoring square-root loop when the discriminant is
//   non-negative (straight to the update when it is negative), and on a
//   final point with a positive critical rate and k the restoring divide.
//   The root and divide loops give one bit per cycle; all products go
//   through the one shared multiplier. sweep_in.ready is high only while
//   the sequencer idles, so no item is taken while another is in flight.
// Reset
//   rst_n clears the sequencer, the point index and the running maximum and
//   loads register reset values (diffusion 1.0, all else 0).
// Stall
//   A finished item waits in the output register; the next item may be
//   accepted meanwhile and is held at its last step until the slot frees.
// ---------------------------------------------------------------------------
module dispersion_sweep_max_growth_core
    import dsmg_pkg::*;
#(
    parameter int MAX_POINTS = 65535,
    parameter int FRAC_BITS  = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    dsmg_in_if.sink           sweep_in,
    dsmg_out_if.source        result_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int PAIRS  = (64 + FRAC_BITS + 1) / 2;
    localparam int RAD_W  = 2 * PAIRS;
    localparam int NUM_W  = 3 + 2 * FRAC_BITS;
    localparam int CNT_W  = $clog2((NUM_W > PAIRS) ? NUM_W : PAIRS);
    localparam logic [63:0] TWO_PI_FULL = (2 * FRAC_BITS >= 32) ?
        (TWO_PI_Q32 << (2 * FRAC_BITS - 32)) : (TWO_PI_Q32 >> (32 - 2 * FRAC_BITS));
    localparam logic [NUM_W-1:0] TWO_PI_NUM = TWO_PI_FULL[NUM_W-1:0];

    // Sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MK   = 5'd1;
    localparam logic [4:0] S_K    = 5'd2;
    localparam logic [4:0] S_MK2  = 5'd3;
    localparam logic [4:0] S_K2   = 5'd4;
    localparam logic [4:0] S_MD1  = 5'd5;
    localparam logic [4:0] S_D1   = 5'd6;
    localparam logic [4:0] S_MD2  = 5'd7;
    localparam logic [4:0] S_D2   = 5'd8;
    localparam logic [4:0] S_MP1  = 5'd9;
    localparam logic [4:0] S_P1   = 5'd10;
    localparam logic [4:0] S_MP2  = 5'd11;
    localparam logic [4:0] S_P2   = 5'd12;
    localparam logic [4:0] S_MP3  = 5'd13;
    localparam logic [4:0] S_DISC = 5'd14;
    localparam logic [4:0] S_SQRT = 5'd15;
    localparam logic [4:0] S_RATE = 5'd16;
    localparam logic [4:0] S_UPD  = 5'd17;
    localparam logic [4:0] S_DIV  = 5'd18;
    localparam logic [4:0] S_OUT  = 5'd19;

    // Configuration registers
    logic signed [31:0] self1_reg, cross1_reg, cross2_reg, self2_reg;
    logic [30:0]        diff1_reg, diff2_reg;
    logic signed [31:0] kstart_reg, kstep_reg;

    // Sequencer and sweep state
    logic [4:0]         state_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic signed [31:0] best_rate_reg, best_k_reg;
    logic               last_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // Working registers
    logic signed [31:0] k_reg, k2_reg, d1_reg, d2_reg, trace_reg, rate_reg;
    logic signed [67:0] det_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [PAIRS-1:0]   root_reg;
    logic [PAIRS+1:0]   rem_reg;
    logic [NUM_W-1:0]   num_reg, quo_reg;
    logic [30:0]        drem_reg;
    logic signed [31:0] crit_rate_reg, crit_k_reg;
    logic               unst_reg, do_wl_reg;

    // Output register
    logic               out_valid_reg;
    logic signed [31:0] o_k_reg, o_rate_reg, o_ck_reg, o_cr_reg;
    logic               o_done_reg, o_unst_reg;
    logic [30:0]        o_wl_reg;

    mul_req_t           mreq;
    logic signed [65:0] prod_reg;

    dsmg_mul u_mul (
        .clk      (clk),
        .req      (mreq),
        .prod_reg (prod_reg)
    );

    // APB: always ready, write on the access phase
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_SELF1:  prdata = self1_reg;
            REG_CROSS1: prdata = cross1_reg;
            REG_CROSS2: prdata = cross2_reg;
            REG_SELF2:  prdata = self2_reg;
            REG_DIFF1:  prdata = {1'b0, diff1_reg};
            REG_DIFF2:  prdata = {1'b0, diff2_reg};
            REG_KSTART: prdata = kstart_reg;
            REG_KSTEP:  prdata = kstep_reg;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self1_reg  <= '0;
            cross1_reg <= '0;
            cross2_reg <= '0;
            self2_reg  <= '0;
            diff1_reg  <= 31'(1) << FRAC_BITS;
            diff2_reg  <= 31'(1) << FRAC_BITS;
            kstart_reg <= '0;
            kstep_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SELF1:  self1_reg  <= pwdata;
                REG_CROSS1: cross1_reg <= pwdata;
                REG_CROSS2: cross2_reg <= pwdata;
                REG_SELF2:  self2_reg  <= pwdata;
                REG_DIFF1:  diff1_reg  <= pwdata[30:0];
                REG_DIFF2:  diff2_reg  <= pwdata[30:0];
                REG_KSTART: kstart_reg <= pwdata;
                REG_KSTEP:  kstep_reg  <= pwdata;
                default:    ;
            endcase
        end
    end

    // Multiplier operand selection
    always_comb
    begin
        mreq.en = 1'b1;
        mreq.a  = '0;
        mreq.b  = '0;
        unique case (state_reg)
            S_MK:
            begin
                mreq.a = $signed({(33 - IDX_W)'(0), idx_reg});
                mreq.b = 33'(kstep_reg);
            end
            S_MK2:
            begin
                mreq.a = 33'(k_reg);
                mreq.b = 33'(k_reg);
            end
            S_MD1:
            begin
                mreq.a = $signed({2'b00, diff1_reg});
                mreq.b = 33'(k2_reg);
            end
            S_MD2:
            begin
                mreq.a = $signed({2'b00, diff2_reg});
                mreq.b = 33'(k2_reg);
            end
            S_MP1:
            begin
                mreq.a = 33'(d1_reg);
                mreq.b = 33'(d2_reg);
            end
            S_MP2:
            begin
                mreq.a = 33'(cross1_reg);
                mreq.b = 33'(cross2_reg);
            end
            S_MP3:
            begin
                mreq.a = 33'(trace_reg);
                mreq.b = 33'(trace_reg);
            end
            default: mreq.en = 1'b0;
        endcase
    end

    // Datapath helpers
    logic signed [XW-1:0]  p_x, p_sh, disc_x, sum_x, sat_in;
    logic [PAIRS+1:0]      rem_sh, trial;
    logic [31:0]           drem_sh, divisor;
    logic signed [31:0]    nb_rate, nb_k;
    logic                  take_best;
    logic [63:0]           quo_x;
    logic [30:0]           wl_val;
    logic                  out_free;

    always_comb
    begin
        p_x       = XW'(prod_reg);
        p_sh      = p_x >>> FRAC_BITS;
        disc_x    = p_sh - (XW'(det_reg) <<< 2);
        sum_x     = XW'(trace_reg) + $signed(XW'(root_reg));
        sat_in    = XW'(self1_reg) - XW'(sat32(p_sh));
        rem_sh    = {rem_reg[PAIRS-1:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        drem_sh   = {drem_reg, num_reg[NUM_W-1]};
        divisor   = {1'b0, crit_k_reg[30:0]};
        take_best = rate_reg > best_rate_reg;
        nb_rate   = take_best ? rate_reg : best_rate_reg;
        nb_k      = take_best ? k_reg : best_k_reg;
        quo_x     = 64'(quo_reg);
        wl_val    = (quo_x > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : quo_x[30:0];
        out_free  = !out_valid_reg || result_out.ready;
    end

    assign sweep_in.ready = (state_reg == S_IDLE);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            best_rate_reg <= INT32_MIN_C;
            best_k_reg    <= '0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the taken item unless a new one is loaded this cycle
            if (out_valid_reg && result_out.ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (sweep_in.valid)
                    begin
                        last_reg  <= sweep_in.final_point;
                        state_reg <= S_MK;
                    end
                end
                S_MK:  state_reg <= S_K;
                S_K:
                begin
                    k_reg     <= sat32(XW'(kstart_reg) + p_x);
                    state_reg <= S_MK2;
                end
                S_MK2: state_reg <= S_K2;
                S_K2:
                begin
                    k2_reg    <= sat32(p_sh);
                    state_reg <= S_MD1;
                end
                S_MD1: state_reg <= S_D1;
                S_D1:
                begin
                    d1_reg    <= sat32(sat_in);
                    state_reg <= S_MD2;
                end
                S_MD2: state_reg <= S_D2;
                S_D2:
                begin
                    d2_reg    <= sat32(XW'(self2_reg) - XW'(sat32(p_sh)));
                    state_reg <= S_MP1;
                end
                S_MP1:
                begin
                    trace_reg <= sat32(XW'(d1_reg) + XW'(d2_reg));
                    state_reg <= S_P1;
                end
                S_P1:
                begin
                    det_reg   <= p_sh[67:0];
                    state_reg <= S_MP2;
                end
                S_MP2: state_reg <= S_P2;
                S_P2:
                begin
                    det_reg   <= det_reg - p_sh[67:0];
                    state_reg <= S_MP3;
                end
                S_MP3: state_reg <= S_DISC;
                S_DISC:
                begin
                    if (disc_x < 0)
                    begin
                        rate_reg  <= trace_reg >>> 1;
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        rad_reg   <= RAD_W'({disc_x[63:0], {FRAC_BITS{1'b0}}});
                        root_reg  <= '0;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    // one result bit per cycle, restoring
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[PAIRS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[PAIRS-2:0], 1'b0};
                    end
                    rad_reg <= rad_reg << 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(PAIRS - 1))
                    begin
                        state_reg <= S_RATE;
                    end
                end
                S_RATE:
                begin
                    rate_reg  <= sat32(sum_x >>> 1);
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    crit_rate_reg <= nb_rate;
                    crit_k_reg    <= nb_k;
                    unst_reg      <= last_reg && (nb_rate > 0);
                    num_reg       <= TWO_PI_NUM;
                    quo_reg       <= '0;
                    drem_reg      <= '0;
                    cnt_reg       <= '0;
                    if (last_reg)
                    begin
                        best_rate_reg <= INT32_MIN_C;
                        best_k_reg    <= '0;
                    end
                    else
                    begin
                        best_rate_reg <= nb_rate;
                        best_k_reg    <= nb_k;
                    end
                    if (last_reg && (nb_rate > 0) && (nb_k > 0))
                    begin
                        do_wl_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        do_wl_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit per cycle
                    if (drem_sh >= divisor)
                    begin
                        drem_reg <= 31'(drem_sh - divisor);
                        quo_reg  <= {quo_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= drem_sh[30:0];
                        quo_reg  <= {quo_reg[NUM_W-2:0], 1'b0};
                    end
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    // hold here until the output slot is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_k_reg       <= k_reg;
                        o_rate_reg    <= rate_reg;
                        o_done_reg    <= last_reg;
                        o_ck_reg      <= crit_k_reg;
                        o_cr_reg      <= crit_rate_reg;
                        o_unst_reg    <= unst_reg;
                        o_wl_reg      <= do_wl_reg ? wl_val : '0;
                        if (last_reg)
                        begin
                            idx_reg <= '0;
                        end
                        else if (idx_reg < IDX_W'(MAX_POINTS - 1))
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_out.valid               = out_valid_reg;
    assign result_out.wavenumber          = o_k_reg;
    assign result_out.growth_rate         = o_rate_reg;
    assign result_out.sweep_done          = o_done_reg;
    assign result_out.critical_wavenumber = o_ck_reg;
    assign result_out.critical_rate       = o_cr_reg;
    assign result_out.unstable            = o_unst_reg;
    assign result_out.wavelength          = o_wl_reg;

endmodule

[src/dsmg_checker.sv]
// Port-level checks for the dispersion sweep core, bound to its top level.
// Depends on dispersion_sweep_max_growth_core.
`timescale 1ns / 1ps
module dsmg_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              sweep_done,
    input logic              unstable,
    input logic signed [31:0] critical_rate,
    input logic [30:0]       wavelength
);

    // a point occupies the sequencer, which holds input ready low once it is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again straight after an item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(critical_rate)))
        else $error("stalled item dropped or changed");

    a_summary_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sweep_done) |-> (!unstable && wavelength == 31'd0))
        else $error("summary fields set on a non-final item");

    a_unstable_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && unstable) |-> (critical_rate > 0))
        else $error("unstable flag without positive rate");

    a_wl_needs_unstable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !unstable) |-> (wavelength == 31'd0))
        else $error("wavelength on a stable sweep");

endmodule

bind dispersion_sweep_max_growth_core dsmg_checker u_dsmg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sweep_in.valid),
    .in_ready      (sweep_in.ready),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .sweep_done    (result_out.sweep_done),
    .unstable      (result_out.unstable),
    .critical_rate (result_out.critical_rate),
    .wavelength    (result_out.wavelength)
);

[bench/dsmg_checker.sv]
// Checker for the dispersion sweep core: watches the APB writes and both item
// channels, predicts each result and compares it. Depends on dsmg_pkg, dsmg_if.
`timescale 1ns / 1ps
module dsmg_scoreboard
    import dsmg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dsmg_in_if          sweep_mon,
    dsmg_out_if         result_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending,
    output int          results_seen
);

    typedef struct {
        logic signed [31:0] wavenumber;
        logic signed [31:0] growth_rate;
        logic               sweep_done;
        logic signed [31:0] critical_wavenumber;
        logic signed [31:0] critical_rate;
        logic               unstable;
        logic [30:0]        wavelength;
    } point_result_t;

    point_result_t expected_points[$];

    logic signed [31:0] self_first, cross_first, cross_second, self_second;
    logic signed [31:0] k_start, k_step;
    logic [30:0]        diff_first, diff_second;
    int unsigned        sweep_pos;
    longint             max_rate, max_rate_k;

    function automatic longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return -64'sh8000_0000;
        return v;
    endfunction

    // floor(sqrt(v * 2^16)), two bits of the radicand per step
    function automatic longint scaled_root(longint v);
        logic [127:0] x, root, rem, trial;
        x = 128'(v) << 16;
        root = '0;
        rem = '0;
        for (int j = 63; j >= 0; j--)
        begin
            rem = (rem << 2) | 128'(x[2*j +: 2]);
            trial = (root << 2) | 128'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 128'd1;
            end
            else
                root = root << 1;
        end
        return longint'(root[63:0]);
    endfunction

    function automatic point_result_t predict_point(logic last);
        point_result_t r;
        longint k, k2, d1, d2, tr, det, disc, rate, wl;
        k  = clamp32(longint'(k_start) + longint'(sweep_pos) * longint'(k_step));
        k2 = clamp32((k * k) >>> 16);
        d1 = clamp32(longint'(self_first) - clamp32((longint'(diff_first) * k2) >>> 16));
        d2 = clamp32(longint'(self_second) - clamp32((longint'(diff_second) * k2) >>> 16));
        tr = clamp32(d1 + d2);
        det = ((d1 * d2) >>> 16)
            - ((longint'(cross_first) * longint'(cross_second)) >>> 16);
        disc = ((tr * tr) >>> 16) - 4 * det;
        if (disc >= 0)
            rate = clamp32((tr + scaled_root(disc)) >>> 1);
        else
            rate = tr >>> 1;
        // strictly greater only: a tie keeps the earlier k
        if (rate > max_rate)
        begin
            max_rate = rate;
            max_rate_k = k;
        end
        wl = 0;
        if (last && max_rate > 0 && max_rate_k > 0)
        begin
            wl = longint'(TWO_PI_Q32) / max_rate_k;
            if (wl > 64'sh7FFF_FFFF)
                wl = 64'sh7FFF_FFFF;
        end
        r.wavenumber = k[31:0];
        r.growth_rate = rate[31:0];
        r.sweep_done = last;
        r.critical_wavenumber = max_rate_k[31:0];
        r.critical_rate = max_rate[31:0];
        r.unstable = last && (max_rate > 0);
        r.wavelength = wl[30:0];
        if (last)
        begin
            sweep_pos = 0;
            max_rate = -64'sh8000_0000;
            max_rate_k = 0;
        end
        else if (sweep_pos < 65534)
            sweep_pos++;
        return r;
    endfunction

    task automatic report(string what, longint want, longint got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_result_t want;
        if (!rst_n)
        begin
            self_first <= '0;
            cross_first <= '0;
            cross_second <= '0;
            self_second <= '0;
            diff_first <= 31'h1_0000;
            diff_second <= 31'h1_0000;
            k_start <= '0;
            k_step <= '0;
            sweep_pos = 0;
            max_rate = -64'sh8000_0000;
            max_rate_k = 0;
            expected_points.delete();
            pending = 0;
            errors = 0;
            results_seen = 0;
        end
        else
        begin
            if (sweep_mon.valid && sweep_mon.ready)
                expected_points.push_back(predict_point(sweep_mon.final_point));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_SELF1:  self_first <= pwdata;
                    REG_CROSS1: cross_first <= pwdata;
                    REG_CROSS2: cross_second <= pwdata;
                    REG_SELF2:  self_second <= pwdata;
                    REG_DIFF1:  diff_first <= pwdata[30:0];
                    REG_DIFF2:  diff_second <= pwdata[30:0];
                    REG_KSTART: k_start <= pwdata;
                    REG_KSTEP:  k_step <= pwdata;
                    default: ;
                endcase
            end
            if (result_mon.valid && result_mon.ready)
            begin
                results_seen++;
                if (expected_points.size() == 0)
                    report("unexpected result, sweep_done", -1, result_mon.sweep_done);
                else
                begin
                    want = expected_points.pop_front();
                    if (result_mon.wavenumber !== want.wavenumber)
                        report("wavenumber", want.wavenumber, result_mon.wavenumber);
                    if (result_mon.growth_rate !== want.growth_rate)
                        report("growth_rate", want.growth_rate, result_mon.growth_rate);
                    if (result_mon.sweep_done !== want.sweep_done)
                        report("sweep_done", want.sweep_done, result_mon.sweep_done);
                    if (result_mon.critical_wavenumber !== want.critical_wavenumber)
                        report("critical_wavenumber", want.critical_wavenumber,
                               result_mon.critical_wavenumber);
                    if (result_mon.critical_rate !== want.critical_rate)
                        report("critical_rate", want.critical_rate, result_mon.critical_rate);
                    if (result_mon.unstable !== want.unstable)
                        report("unstable", want.unstable, result_mon.unstable);
                    if (result_mon.wavelength !== want.wavelength)
                        report("wavelength", want.wavelength, result_mon.wavelength);
                end
            end
            pending = expected_points.size();
        end
    end

endmodule

[bench/tb_dispersion_sweep_max_growth_core.sv]
// Testbench top for the dispersion sweep core: clock, reset, APB set-up, sweep
// stimulus, verdict. Depends on dsmg_pkg, dsmg_if, the core, dsmg_scoreboard.
`timescale 1ns / 1ps
module tb_dispersion_sweep_max_growth_core
    import dsmg_pkg::*;
;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, results_seen;
    int points_sent = 0;
    int sweeps_sent = 0;
    int configs_used = 0;
    bit calm = 1'b0;        // suppresses idling on both sides
    bit hold_req = 1'b0;    // asks the result side for one long hold-off

    dsmg_in_if  sweep_ch ();
    dsmg_out_if result_ch ();

    always #2 clk = ~clk;

    dispersion_sweep_max_growth_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sweep_in   (sweep_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    dsmg_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .sweep_mon    (sweep_ch),
        .result_mon   (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Result side: random stalls, a calm stretch, and one long hold-off
    // counted here so the core fills up and drops its input ready.
    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                result_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_taken = 1'b1;
            end
            else
                result_ch.ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    // Setup cycle then access cycle; the register takes the value at the
    // edge where penable is high.
    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_matrix(logic [31:0] s1, logic [31:0] c1, logic [31:0] c2,
                               logic [31:0] s2, logic [31:0] df1, logic [31:0] df2,
                               logic [31:0] kst, logic [31:0] kstep);
        apb_write(REG_SELF1, s1);
        apb_write(REG_CROSS1, c1);
        apb_write(REG_CROSS2, c2);
        apb_write(REG_SELF2, s2);
        apb_write(REG_DIFF1, df1);
        apb_write(REG_DIFF2, df2);
        apb_write(REG_KSTART, kst);
        apb_write(REG_KSTEP, kstep);
        configs_used++;
    endtask

    // Offer one sweep point; valid stays high across back-to-back items.
    task automatic send_point(logic last);
        if (!calm && $urandom_range(99) < 7)
        begin
            sweep_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sweep_ch.valid <= 1'b1;
        sweep_ch.final_point <= last;
        do
            @(posedge clk);
        while (!sweep_ch.ready);
        points_sent++;
    endtask

    task automatic send_sweep(int n);
        for (int i = 0; i < n; i++)
            send_point(i == n - 1);
        sweeps_sent++;
    endtask

    // Hold the input until every result is back, then let the core settle.
    task automatic drain();
        int guard;
        sweep_ch.valid <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (pending != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    // Small Q16.16 value, within about +/-4.0
    function automatic logic [31:0] small_q(int span);
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    initial
    begin
        sweep_ch.valid = 1'b0;
        sweep_ch.final_point = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset values: single-point sweep, then a flat sweep where every
        // rate ties and the first k must be kept.
        send_sweep(1);
        send_sweep(4);
        drain();

        // Pattern-forming matrix: stable at k=0, unstable band at finite k.
        load_matrix(32'h0000_8000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000,
                    32'h0000_0800, 32'h0004_0000, 32'h0000_0000, 32'h0000_4000);
        send_sweep(8);
        send_sweep(2);
        drain();

        // Extremes: all at the positive limit, then mostly at the negative one.
        load_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sweep(3);
        drain();
        load_matrix(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
        send_sweep(3);
        drain();

        for (int phase = 0; points_sent < 570; phase++)
        begin
            if (phase % 4 == 3)
                load_matrix($urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom);
            else
                load_matrix(small_q(262144), small_q(262144), small_q(262144),
                            small_q(262144), $urandom_range(262144),
                            $urandom_range(1048576), small_q(131072),
                            small_q(16384));
            calm = (phase == 3);
            if (phase == 5)
                hold_req = 1'b1;
            for (int s = 0; s < 8; s++)
                send_sweep(($urandom_range(9) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10));
            drain();
            calm = 1'b0;
        end

        drain();
        $display("covered %0d sweeps, %0d points, %0d results under %0d matrix settings",
                 sweeps_sent, points_sent, results_seen, configs_used);
        $display("including a long result hold-off, a calm stretch and saturating extremes");
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Run limit, well above the slowest correct run.
    initial
    begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
src/dsmg_pkg.sv
src/dsmg_if.sv
src/dsmg_mul.sv
src/dispersion_sweep_max_growth_core.sv
src/dsmg_checker.sv
bench/dsmg_checker.sv
bench/tb_dispersion_sweep_max_growth_core.sv
